// ----- hw/rtl/rvalu_pkg.sv -----
`default_nettype none
// Shared types and codes for the RV32IM ALU pipeline.
// No dependencies.
package rvalu_pkg;

  localparam int XLEN = 32;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Item carried through the divider pipeline
  typedef struct packed {
    logic            valid;
    logic            kind_div;  // result comes from divider
    logic            sel_rem;   // remainder rather than quotient
    logic            neg;       // negate divider result
    logic            spec;      // fixed result held in res
    logic [XLEN-1:0] res;
    logic [XLEN-1:0] rmd;
    logic [XLEN-1:0] quo;
    logic [XLEN-1:0] dsr;
  } carry_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rvalu_div.sv -----
`default_nettype none
// Bit-per-stage restoring divider pipeline, one quotient bit per register stage.
// Depends on rvalu_pkg.
module rvalu_div
  import rvalu_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire carry_t d_in,
  output carry_t      d_out
);

  carry_t stage_r [XLEN];

  for (genvar i = 0; i < XLEN; i++) begin : g_stage
    carry_t prev;
    carry_t stage_nxt;
    logic [XLEN:0] shifted;
    logic [XLEN:0] diff;

    if (i == 0) begin : g_first
      assign prev = d_in;
    end else begin : g_next
      assign prev = stage_r[i-1];
    end

    always_comb begin
      stage_nxt = prev;
      shifted   = {prev.rmd, prev.quo[XLEN-1]};
      diff      = shifted - {1'b0, prev.dsr};
      stage_nxt.quo = {prev.quo[XLEN-2:0], ~diff[XLEN]};
      stage_nxt.rmd = diff[XLEN] ? shifted[XLEN-1:0] : diff[XLEN-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r[i].valid <= 1'b0;
      end else if (en) begin
        stage_r[i] <= stage_nxt;
      end
    end
  end

  assign d_out = stage_r[XLEN-1];

endmodule
`default_nettype wire

// ----- hw/rtl/rv32im_alu_unit.sv -----
`default_nettype none
// RV32IM register-register ALU, fully pipelined top level.
// Depends on rvalu_pkg and rvalu_div.
//
// Usage:
//   Input channel in_*: one item per handshake carrying funct3, funct7 and
//   the two source words. Result channel out_*: one 32-bit result per item,
//   in the order the items were taken.
//   From input handshake to out_tvalid an item passes the input register,
//   decode and partial products, product sum, multiply fix-up, 32 divider
//   stages (one quotient bit each) and sign fix-up into the output register.
//   Every operation takes the same path, so order is kept by construction.
//   Throughput is one item per cycle when not stalled; the 32-stage divider
//   sets the depth, the 16x16 partial products set the multiplier split.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds; in_tready follows !out_tvalid || out_tready, so bubbles ahead of
//   the output still fill while it is empty.
//   Reset (rst_n low, synchronous) clears all valid bits; payload is not
//   reset.
module rv32im_alu_unit
  import rvalu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [79:0] in_tdata,   // funct3[2:0], funct7[9:3], operand_a[41:10],
                                       // operand_b[73:42], zero pad
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata   // alu_result[31:0]
);

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 0: input register
  logic            s0_valid_r;
  logic [2:0]      s0_f3_r;
  logic [6:0]      s0_f7_r;
  logic [XLEN-1:0] s0_a_r, s0_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_f3_r <= in_tdata[2:0];
      s0_f7_r <= in_tdata[9:3];
      s0_a_r  <= in_tdata[41:10];
      s0_b_r  <= in_tdata[73:42];
    end
  end

  // stage 1: base ops, partial products, divider set-up
  carry_t          s1_nxt, s1_r;
  logic            s1_mul_nxt, s1_mul_r;
  logic [2:0]      s1_f3_r;
  logic [31:0]     pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic            is_base, is_alt, is_md, sgn_div;
  logic [4:0]      shamt;
  logic [XLEN-1:0] abs_a, abs_b;

  always_comb begin
    is_base = (s0_f7_r == F7_BASE);
    is_alt  = (s0_f7_r == F7_ALT);
    is_md   = (s0_f7_r == F7_MULDIV);
    shamt   = s0_b_r[4:0];
    abs_a   = s0_a_r[XLEN-1] ? (~s0_a_r + XLEN'(1)) : s0_a_r;
    abs_b   = s0_b_r[XLEN-1] ? (~s0_b_r + XLEN'(1)) : s0_b_r;
    sgn_div = (s0_f3_r == F3_XOR) || (s0_f3_r == F3_OR);
    s1_nxt          = '0;
    s1_nxt.valid    = s0_valid_r;
    s1_nxt.quo      = s0_a_r;
    s1_nxt.dsr      = s0_b_r;
    s1_mul_nxt      = 1'b0;
    case (s0_f3_r)
      F3_ADD:  s1_nxt.res = is_base ? s0_a_r + s0_b_r : (is_alt ? s0_a_r - s0_b_r : '0);
      F3_SLL:  s1_nxt.res = is_base ? s0_a_r << shamt : '0;
      F3_SLT:  s1_nxt.res = {31'd0, is_base && ($signed(s0_a_r) < $signed(s0_b_r))};
      F3_SLTU: s1_nxt.res = {31'd0, is_base && (s0_a_r < s0_b_r)};
      F3_XOR:  s1_nxt.res = is_base ? s0_a_r ^ s0_b_r : '0;
      F3_SRL:  s1_nxt.res = is_base ? s0_a_r >> shamt :
                            (is_alt ? XLEN'($signed(s0_a_r) >>> shamt) : '0);
      F3_OR:   s1_nxt.res = is_base ? s0_a_r | s0_b_r : '0;
      F3_AND:  s1_nxt.res = is_base ? s0_a_r & s0_b_r : '0;
      default: s1_nxt.res = '0;
    endcase
    if (is_md) begin
      if (s0_f3_r[2]) begin
        s1_nxt.kind_div = 1'b1;
        s1_nxt.sel_rem  = s0_f3_r[1];
        s1_nxt.quo      = sgn_div ? abs_a : s0_a_r;
        s1_nxt.dsr      = sgn_div ? abs_b : s0_b_r;
        s1_nxt.neg      = sgn_div && (s0_f3_r[1] ? s0_a_r[XLEN-1]
                                                 : (s0_a_r[XLEN-1] ^ s0_b_r[XLEN-1]));
        s1_nxt.spec     = (s0_b_r == '0);
        s1_nxt.res      = s0_f3_r[1] ? s0_a_r : '1;
      end else begin
        s1_mul_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (en) begin
      s1_r <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mul_r <= s1_mul_nxt;
      s1_f3_r  <= s0_f3_r;
      pp_ll_r  <= 32'(s0_a_r[15:0])  * 32'(s0_b_r[15:0]);
      pp_lh_r  <= 32'(s0_a_r[15:0])  * 32'(s0_b_r[31:16]);
      pp_hl_r  <= 32'(s0_a_r[31:16]) * 32'(s0_b_r[15:0]);
      pp_hh_r  <= 32'(s0_a_r[31:16]) * 32'(s0_b_r[31:16]);
    end
  end

  // stage 2: unsigned product sum
  carry_t      s2_r;
  logic        s2_mul_r;
  logic [2:0]  s2_f3_r;
  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (en) begin
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mul_r <= s1_mul_r;
      s2_f3_r  <= s1_f3_r;
      prod_r   <= {32'd0, pp_ll_r} + {16'd0, pp_lh_r, 16'd0}
                + {16'd0, pp_hl_r, 16'd0} + {pp_hh_r, 32'd0};
    end
  end

  // stage 3: signed high-word correction, multiply result
  carry_t          s3_nxt, s3_r;
  logic [XLEN-1:0] corr_a, corr_b;

  always_comb begin
    s3_nxt = s2_r;
    corr_a = (s2_r.quo[XLEN-1] && (s2_f3_r == F3_SLL || s2_f3_r == F3_SLT))
             ? s2_r.dsr : '0;
    corr_b = (s2_r.dsr[XLEN-1] && (s2_f3_r == F3_SLL)) ? s2_r.quo : '0;
    if (s2_mul_r) begin
      s3_nxt.res = (s2_f3_r == F3_ADD) ? prod_r[31:0]
                                       : prod_r[63:32] - corr_a - corr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else if (en) begin
      s3_r <= s3_nxt;
    end
  end

  // divider pipeline; remainder starts at zero
  carry_t div_in, div_out;
  always_comb begin
    div_in     = s3_r;
    div_in.rmd = '0;
  end

  rvalu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d_in  (div_in),
    .d_out (div_out)
  );

  // final: sign fix-up into output register
  logic            out_valid_r;
  logic [XLEN-1:0] out_data_r, raw, fin;

  always_comb begin
    raw = div_out.sel_rem ? div_out.rmd : div_out.quo;
    if (!div_out.kind_div || div_out.spec) begin
      fin = div_out.res;
    end else begin
      fin = div_out.neg ? (~raw + XLEN'(1)) : raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (div_out.valid && div_out.kind_div && !div_out.spec) |-> (div_out.rmd < div_out.dsr))
    else $error("divider remainder not below divisor");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result lost while stalled");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking bench for rv32im_alu_unit: drives funct3/funct7/operand items,
// predicts each result word and compares in order. Depends on rvalu_pkg and the RTL.
module tb_top;
  import rvalu_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  typedef struct packed {
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a;
    logic [31:0] b;
  } alu_op_t;

  alu_op_t     pending_ops[$];
  logic [31:0] want_results[$];
  bit          failed = 1'b0;
  bit          stim_done = 1'b0;

  rv32im_alu_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // tdata layout: funct3 lowest, then funct7, operand_a, operand_b, zero pad
  function automatic logic [79:0] pack_op(alu_op_t op);
    return {6'h0, op.b, op.a, op.f7, op.f3};
  endfunction

  // Result word for one item, RV32IM semantics
  function automatic logic [31:0] alu_predict(alu_op_t op);
    logic [31:0] a, b, q, r;
    logic [63:0] p;
    logic [4:0]  sh;
    bit          base, alt, md;
    a = op.a; b = op.b; sh = b[4:0];
    base = (op.f7 == F7_BASE); alt = (op.f7 == F7_ALT); md = (op.f7 == F7_MULDIV);
    case (op.f3)
      F3_ADD:  return base ? a + b : alt ? a - b : md ? a * b : 32'h0;
      F3_SLL: begin
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        return base ? a << sh : md ? p[63:32] : 32'h0;
      end
      F3_SLT: begin
        p = {{32{a[31]}}, a} * {32'h0, b};
        return base ? {31'h0, $signed(a) < $signed(b)} : md ? p[63:32] : 32'h0;
      end
      F3_SLTU: begin
        p = {32'h0, a} * {32'h0, b};
        return base ? {31'h0, a < b} : md ? p[63:32] : 32'h0;
      end
      F3_XOR: begin
        if (base) return a ^ b;
        if (!md) return 32'h0;
        if (b == 0) return 32'hFFFF_FFFF;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
        q = (a[31] ? -a : a) / (b[31] ? -b : b);
        return (a[31] ^ b[31]) ? -q : q;
      end
      F3_SRL: begin
        if (base) return a >> sh;
        if (alt) return $signed(a) >>> sh;
        if (md) return (b == 0) ? 32'hFFFF_FFFF : a / b;
        return 32'h0;
      end
      F3_OR: begin
        if (base) return a | b;
        if (!md) return 32'h0;
        if (b == 0) return a;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'h0;
        r = (a[31] ? -a : a) % (b[31] ? -b : b);
        return a[31] ? -r : r;
      end
      default: return base ? a & b : md ? ((b == 0) ? a : a % b) : 32'h0;
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 40);
      5: return -$urandom_range(1, 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6:0] rand_f7();
    case ($urandom_range(0, 9))
      0, 1, 2: return F7_BASE;
      3, 4:    return F7_ALT;
      5, 6, 7: return F7_MULDIV;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // Driver: one item from the queue, a random gap before each
  int gap_in = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        void'(pending_ops.pop_front());
        gap_in <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap_in == 0 && pending_ops.size() > 0 && $urandom_range(0, 1)) begin
          in_tdata <= pack_op(pending_ops[0]);
        end else begin
          in_tvalid <= 1'b0;
        end
      end else if (!in_tvalid && pending_ops.size() > 0) begin
        if (gap_in > 0) gap_in <= gap_in - 1;
        else begin
          in_tvalid <= 1'b1;
          in_tdata <= pack_op(pending_ops[0]);
        end
      end
    end
  end

  // Receiver back-pressure
  int stall_out = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_out > 0) begin
        stall_out <= stall_out - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && out_tready && $urandom_range(0, 2) == 0)
          stall_out <= $urandom_range(0, 18);
      end
    end
  end

  // Monitor: expectation at input accept, compare at output accept
  always @(posedge clk) begin
    logic [31:0] want;
    alu_op_t     got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        got.f3 = in_tdata[2:0];
        got.f7 = in_tdata[9:3];
        got.a  = in_tdata[41:10];
        got.b  = in_tdata[73:42];
        want_results.push_back(alu_predict(got));
      end
      if (out_tvalid && out_tready) begin
        if (want_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          failed = 1'b1;
        end else begin
          want = want_results.pop_front();
          if (want !== out_tdata) begin
            $display("%0t: alu_result mismatch, expected %h, actual %h",
                     $time, want, out_tdata);
            failed = 1'b1;
          end
        end
      end
    end
  end

  initial begin
    alu_op_t op;
    logic [6:0] f7s[3];
    f7s = '{F7_BASE, F7_ALT, F7_MULDIV};
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // Directed: every funct3 with funct7 base, alt and muldiv, corner operands
    for (int f = 0; f < 8; f++)
      for (int v = 0; v < 3; v++)
        pending_ops.push_back('{f[2:0], f7s[v], 32'h8000_0000, 32'hFFFF_FFFF});
    pending_ops.push_back('{F3_XOR, F7_MULDIV, 32'h7FFF_FFFF, 32'h0});
    pending_ops.push_back('{F3_OR, F7_MULDIV, 32'hFFFF_FFF9, 32'h0});
    pending_ops.push_back('{F3_SRL, F7_MULDIV, 32'hFFFF_FFFF, 32'h0});
    pending_ops.push_back('{F3_AND, F7_MULDIV, 32'hFFFF_FFFF, 32'h0});
    pending_ops.push_back('{F3_OR, F7_MULDIV, 32'hFFFF_FFF9, 32'h2});
    pending_ops.push_back('{F3_SRL, F7_ALT, 32'h8000_0000, 32'h1F});
    pending_ops.push_back('{F3_AND, 7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    for (int i = 0; i < 550; i++) begin
      op.f3 = 3'($urandom_range(0, 7));
      op.f7 = rand_f7();
      op.a = rand_word();
      op.b = rand_word();
      pending_ops.push_back(op);
    end
    wait (pending_ops.size() == 0);
    wait (want_results.size() == 0);
    repeat (60) @(posedge clk);
    if (!failed && want_results.size() == 0) $display("rv32im_alu_unit test passed");
    else $display("rv32im_alu_unit test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("rv32im_alu_unit test failed");
    $finish;
  end

endmodule
